>>> rtl/mbt_pkg.sv
package mbt_pkg;

   // Address and trie geometry
   localparam int ADDR_BITS = 32;
   localparam int STRIDE = 3;
   localparam int NODE_COUNT = 1024;
   localparam int PORT_BITS = 8;

   localparam int LEVELS = (ADDR_BITS + STRIDE - 1) / STRIDE;
   localparam int WALK_BITS = LEVELS * STRIDE;
   localparam int PAD_BITS = WALK_BITS - ADDR_BITS;
   localparam int FANOUT = 1 << STRIDE;
   localparam int LAST_BITS = (LEVELS - 1) * STRIDE;

   localparam int NODE_BITS = $clog2(NODE_COUNT);
   localparam int CNT_BITS = $clog2(NODE_COUNT + 1);

   // Item field widths
   localparam int PLEN_BITS = 6;
   localparam int RPORT_BITS = 8;
   localparam int STATUS_BITS = 2;

   localparam logic [PLEN_BITS-1:0] PLEN_MAX = PLEN_BITS'(ADDR_BITS);

   // Commands
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_ROUTE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_POOL_FULL = 2'd2;

   typedef logic [STRIDE-1:0] chunk_type;
   typedef logic [NODE_BITS-1:0] node_type;

   // One trie entry: route and child link
   typedef struct packed {
      logic                 valid;
      logic [PORT_BITS-1:0] port;
      logic [PLEN_BITS-1:0] plen;
      node_type             child;
   } entry_type;

   // One trie node: all entries of a stride
   typedef entry_type [FANOUT-1:0] row_type;

   // Inputs of the per-level unit
   typedef struct packed {
      row_type              row;
      chunk_type            chunk;
      logic [PLEN_BITS-1:0] plen;
      logic [PORT_BITS-1:0] port;
      logic [PLEN_BITS-1:0] lvl_bits;
      node_type             new_node;
   } level_in_type;

   // Outputs of the per-level unit
   typedef struct packed {
      entry_type sel_entry;
      row_type   expand_row;
      row_type   link_row;
      logic      is_final;
      logic      is_last;
   } level_out_type;

endpackage

>>> rtl/mbt_if.sv
interface mbt_req_if;
   import mbt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [ADDR_BITS-1:0]  addr;
   logic [PLEN_BITS-1:0]  prefix_len;
   logic [RPORT_BITS-1:0] route_port;

   modport source (output valid, cmd, addr, prefix_len, route_port, input ready);
   modport sink (input valid, cmd, addr, prefix_len, route_port, output ready);
endinterface

interface mbt_rsp_if;
   import mbt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [RPORT_BITS-1:0]  out_port;
   logic                   hit;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, out_port, hit, status, input ready);
   modport sink (input valid, out_port, hit, status, output ready);
endinterface

>>> rtl/mbt_node_mem.sv
module mbt_node_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mbt_pkg::NODE_BITS-1:0] rd_addr,
   input  logic                       wr_en,
   input  logic [mbt_pkg::NODE_BITS-1:0] wr_addr,
   input  mbt_pkg::row_type           wr_data,
   output mbt_pkg::row_type           rd_data,
   output logic                       clear_busy
);
   import mbt_pkg::*;

   row_type mem [NODE_COUNT];
   row_type rd_data_ff;
   logic [CNT_BITS-1:0] clr_cnt_ff;
   logic [CNT_BITS-1:0] clr_cnt_in;

   // Sweep every node row to zero after reset
   assign clear_busy = (clr_cnt_ff != CNT_BITS'(NODE_COUNT));

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (clear_busy) begin
         clr_cnt_in = clr_cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (clear_busy) begin
         mem[clr_cnt_ff[NODE_BITS-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mbt_level_unit.sv
module mbt_level_unit (
   input  mbt_pkg::level_in_type  lin,
   output mbt_pkg::level_out_type lout
);
   import mbt_pkg::*;

   always_comb begin
      logic [PLEN_BITS-1:0] used;
      chunk_type            mask;
      logic                 covered;
      logic                 wins;
      entry_type            e;

      // Pick the entry addressed by this level's chunk
      lout.sel_entry = lin.row[lin.chunk];

      // Last stride of the prefix, and last level of the address
      lout.is_final = ({1'b0, lin.plen}) <=
                      ({1'b0, lin.lvl_bits} + (PLEN_BITS + 1)'(STRIDE));
      lout.is_last = (lin.lvl_bits == PLEN_BITS'(LAST_BITS));

      // Bits of the chunk that the prefix fixes
      used = lin.plen - lin.lvl_bits;
      mask = ~({STRIDE{1'b1}} >> used);

      // Expand the route over the covered entries; a shorter one never overrides
      lout.expand_row = lin.row;
      for (int k = 0; k < FANOUT; k++) begin
         e = lin.row[k];
         covered = (((STRIDE'(k)) ^ lin.chunk) & mask) == '0;
         wins = !e.valid || (e.plen <= lin.plen);
         if (covered && wins) begin
            lout.expand_row[k].valid = 1'b1;
            lout.expand_row[k].port = lin.port;
            lout.expand_row[k].plen = lin.plen;
         end
      end

      // Link a freshly allocated child under the selected entry
      lout.link_row = lin.row;
      lout.link_row[lin.chunk].child = lin.new_node;
   end

endmodule

>>> rtl/multibit_trie_route_lookup.sv
// Lookup: walks D trie levels from accept to result valid, D = trie levels walked (1 to 11).
// Insert: walks L levels, L = levels down to the prefix's last stride (1 to 11).
// A new item is accepted only after the last one has finished, and an untaken result
// holds the sequencer; one node-memory read per level.
// Reset: synchronous; a clearing pass then zeroes the 1024 node rows, one row a cycle,
// and req_ch.ready stays low until that pass is done.
module multibit_trie_route_lookup (
   input logic clock,
   input logic reset,
   mbt_req_if.sink   req_ch,
   mbt_rsp_if.source rsp_ch
);
   import mbt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic                   cmd_ff, cmd_in;
   logic [WALK_BITS-1:0]   addr_sh_ff, addr_sh_in;
   logic [PLEN_BITS-1:0]   plen_ff, plen_in;
   logic [PORT_BITS-1:0]   port_ff, port_in;
   node_type               node_ff, node_in;
   logic [PLEN_BITS-1:0]   lvl_bits_ff, lvl_bits_in;
   logic                   found_ff, found_in;
   logic [PORT_BITS-1:0]   best_ff, best_in;
   logic [CNT_BITS-1:0]    next_free_ff, next_free_in;
   logic [RPORT_BITS-1:0]  res_port_ff, res_port_in;
   logic                   res_hit_ff, res_hit_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RPORT_BITS-1:0]  rsp_port_ff, rsp_port_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   node_type      mem_rd_addr;
   logic          mem_wr_en;
   node_type      mem_wr_addr;
   row_type       mem_wr_data;
   row_type       mem_rd_data;
   logic          clear_busy;
   logic          req_ready;
   level_in_type  lvl_in;
   level_out_type lvl_out;
   entry_type     e;
   logic          found_now;
   logic [PORT_BITS-1:0] best_now;
   logic [PLEN_BITS-1:0] plen_sat;

   mbt_node_mem u_node_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (mem_rd_addr),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_data    (mem_rd_data),
      .clear_busy (clear_busy)
   );

   // Shared per-level unit
   always_comb begin
      lvl_in.row = mem_rd_data;
      lvl_in.chunk = addr_sh_ff[WALK_BITS-1 -: STRIDE];
      lvl_in.plen = plen_ff;
      lvl_in.port = port_ff;
      lvl_in.lvl_bits = lvl_bits_ff;
      lvl_in.new_node = next_free_ff[NODE_BITS-1:0];
   end

   mbt_level_unit u_level_unit (
      .lin  (lvl_in),
      .lout (lvl_out)
   );

   assign req_ready = (state_ff == S_IDLE) && !clear_busy;
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_port = rsp_port_ff;
   assign rsp_ch.hit = rsp_hit_ff;
   assign rsp_ch.status = rsp_status_ff;

   assign e = lvl_out.sel_entry;
   assign found_now = found_ff || e.valid;
   assign best_now = e.valid ? e.port : best_ff;
   assign plen_sat = (req_ch.prefix_len > PLEN_MAX) ? PLEN_MAX : req_ch.prefix_len;

   // Sequencer: one trie level per cycle while walking; an untaken result holds it
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      addr_sh_in = addr_sh_ff;
      plen_in = plen_ff;
      port_in = port_ff;
      node_in = node_ff;
      lvl_bits_in = lvl_bits_ff;
      found_in = found_ff;
      best_in = best_ff;
      next_free_in = next_free_ff;
      res_port_in = res_port_ff;
      res_hit_in = res_hit_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_port_in = rsp_port_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      mem_rd_addr = node_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = node_ff;
      mem_wr_data = lvl_out.expand_row;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && req_ready) begin
               cmd_in = req_ch.cmd;
               addr_sh_in = WALK_BITS'(req_ch.addr) << PAD_BITS;
               plen_in = plen_sat;
               port_in = PORT_BITS'(req_ch.route_port);
               node_in = '0;
               lvl_bits_in = '0;
               found_in = 1'b0;
               best_in = '0;
               mem_rd_addr = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (cmd_ff == CMD_LOOKUP) begin
               found_in = found_now;
               best_in = best_now;
               res_port_in = RPORT_BITS'(best_now);
               res_hit_in = found_now;
               res_status_in = found_now ? STATUS_OK : STATUS_NO_ROUTE;
               if ((e.child == '0) || lvl_out.is_last) begin
                  state_in = S_FINISH;
               end else begin
                  node_in = e.child;
                  mem_rd_addr = e.child;
                  addr_sh_in = addr_sh_ff << STRIDE;
                  lvl_bits_in = lvl_bits_ff + PLEN_BITS'(STRIDE);
               end
            end else begin
               res_port_in = '0;
               res_hit_in = 1'b0;
               res_status_in = STATUS_OK;
               if (lvl_out.is_final) begin
                  mem_wr_en = 1'b1;
                  mem_wr_data = lvl_out.expand_row;
                  state_in = S_FINISH;
               end else if (e.child != '0) begin
                  node_in = e.child;
                  mem_rd_addr = e.child;
                  addr_sh_in = addr_sh_ff << STRIDE;
                  lvl_bits_in = lvl_bits_ff + PLEN_BITS'(STRIDE);
               end else if (next_free_ff == CNT_BITS'(NODE_COUNT)) begin
                  res_status_in = STATUS_POOL_FULL;
                  state_in = S_FINISH;
               end else begin
                  // Allocate a child node and descend into it
                  mem_wr_en = 1'b1;
                  mem_wr_data = lvl_out.link_row;
                  next_free_in = next_free_ff + CNT_BITS'(1);
                  node_in = next_free_ff[NODE_BITS-1:0];
                  mem_rd_addr = next_free_ff[NODE_BITS-1:0];
                  addr_sh_in = addr_sh_ff << STRIDE;
                  lvl_bits_in = lvl_bits_ff + PLEN_BITS'(STRIDE);
               end
            end
         end
         S_FINISH: begin
            // Hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_port_in = res_port_ff;
               rsp_hit_in = res_hit_ff;
               rsp_status_in = res_status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         next_free_ff <= CNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      addr_sh_ff <= addr_sh_in;
      plen_ff <= plen_in;
      port_ff <= port_in;
      node_ff <= node_in;
      lvl_bits_ff <= lvl_bits_in;
      found_ff <= found_in;
      best_ff <= best_in;
      res_port_ff <= res_port_in;
      res_hit_ff <= res_hit_in;
      res_status_ff <= res_status_in;
      rsp_port_ff <= rsp_port_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The pool pointer only ever steps up by one
   a_free_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (next_free_ff == $past(next_free_ff)) ||
               (next_free_ff == $past(next_free_ff) + CNT_BITS'(1)))
      else $error("node pool pointer moved by more than one");

   // No item enters while the node memory is being cleared
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ch.ready)
      else $error("item accepted during clearing pass");

   // A child link write never hits the row being read
   a_link_rw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && mem_wr_en && !lvl_out.is_final) |-> mem_wr_addr != mem_rd_addr)
      else $error("link write collides with the next level read");

   // A pending result that is not taken keeps the sequencer waiting
   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ch.ready) |=> state_ff == S_FINISH)
      else $error("result overwrote an untaken result");

endmodule
